// File: hw/rtl/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types and constants for the toolpath point decimator.
// ----------------------------------------------------------------------------
package tpd_pkg;

   localparam int COORD_BITS  = 24;
   localparam int CFG_BITS    = 50;
   localparam int CSR_IDX_BITS = 4;

   // distance datapath widths: exact differences, exact squares, exact sum
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int SQ_BITS   = 2 * DIFF_BITS;
   localparam int SUM_BITS  = SQ_BITS + 2;
   localparam int CMP_BITS  = (SUM_BITS > CFG_BITS) ? SUM_BITS : CFG_BITS;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // register reset values
   localparam logic [CFG_BITS-1:0] MIN_SPACE_SQ_RESET = CFG_BITS'(41943);
   localparam logic [CFG_BITS-1:0] END_EPS_SQ_RESET   = CFG_BITS'(16);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_SPACE_SQ = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_END_EPS_SQ   = CSR_IDX_BITS'(1);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      logic      end_of_input_path;
   } req_word_type;

   typedef struct packed {
      coord_type kept_x;
      coord_type kept_y;
      coord_type kept_z;
      logic      end_of_output_path;
      logic      too_short;
   } rsp_word_type;

   // role of a point within its path, decided by the front
   typedef enum logic [1:0] {
      KIND_FIRST,
      KIND_MIDDLE,
      KIND_SHORT,
      KIND_FINAL
   } kind_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      kind_type  kind;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic avail;
   } q_stat_type;

endpackage

// File: hw/rtl/tpd_front.sv
// ----------------------------------------------------------------------------
// tpd_front
// Accepts input words and tags each point with its role in the path.
// ----------------------------------------------------------------------------
module tpd_front import tpd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   input  q_stat_type   q_stat,
   output logic         q_push,
   output q_entry_type  q_entry
);

   typedef enum logic [1:0] {
      SEEN_NONE,
      SEEN_ONE,
      SEEN_MANY
   } seen_type;

   seen_type    seen_ff, seen_in;
   logic        valid_ff;
   q_entry_type entry_ff;
   kind_type    kind_in;
   logic        accept;

   assign req_stall = valid_ff & q_stat.full;
   assign accept    = req_valid & ~req_stall;
   assign q_push    = valid_ff & ~q_stat.full;
   assign q_entry   = entry_ff;

   always_comb begin
      kind_in = KIND_MIDDLE;
      seen_in = seen_ff;
      case (seen_ff)
         SEEN_NONE: begin
            if (req_word.end_of_input_path) begin
               kind_in = KIND_SHORT;
               seen_in = SEEN_NONE;
            end else begin
               kind_in = KIND_FIRST;
               seen_in = SEEN_ONE;
            end
         end
         SEEN_ONE: begin
            if (req_word.end_of_input_path) begin
               kind_in = KIND_SHORT;
               seen_in = SEEN_NONE;
            end else begin
               kind_in = KIND_MIDDLE;
               seen_in = SEEN_MANY;
            end
         end
         SEEN_MANY: begin
            if (req_word.end_of_input_path) begin
               kind_in = KIND_FINAL;
               seen_in = SEEN_NONE;
            end else begin
               kind_in = KIND_MIDDLE;
               seen_in = SEEN_MANY;
            end
         end
         default: begin
            kind_in = KIND_MIDDLE;
            seen_in = SEEN_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= SEEN_NONE;
         valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            seen_ff        <= seen_in;
            entry_ff.x     <= req_word.point_x;
            entry_ff.y     <= req_word.point_y;
            entry_ff.z     <= req_word.point_z;
            entry_ff.kind  <= kind_in;
         end
         if (!req_stall) begin
            valid_ff <= req_valid;
         end
      end
   end

endmodule

// File: hw/rtl/tpd_queue.sv
// ----------------------------------------------------------------------------
// tpd_queue
// Short FIFO of classified points between front and back.
// ----------------------------------------------------------------------------
module tpd_queue import tpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   input  logic        pop,
   output q_entry_type head,
   output q_stat_type  stat
);

   q_entry_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]    wr_ptr_ff;
   logic [QPTR_BITS-1:0]    rd_ptr_ff;
   logic [QCNT_BITS-1:0]    count_ff;
   logic                    do_push;
   logic                    do_pop;

   assign stat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign stat.avail = (count_ff != '0);
   assign do_push    = push & ~stat.full;
   assign do_pop     = pop & stat.avail;
   assign head       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCNT_BITS'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hw/rtl/tpd_back.sv
// ----------------------------------------------------------------------------
// tpd_back
// Distance test against the held point and result word generation.
// ----------------------------------------------------------------------------
module tpd_back import tpd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [CFG_BITS-1:0] min_space_sq,
   input  logic [CFG_BITS-1:0] end_eps_sq,
   input  q_stat_type          q_stat,
   input  q_entry_type         q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_word_type        rsp_word
);

   coord_type    held_x_ff, held_y_ff, held_z_ff;
   logic         any_emitted_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   logic         pend_valid_ff;
   rsp_word_type pend_word_ff;

   logic signed [DIFF_BITS-1:0] dx, dy, dz;
   logic signed [SQ_BITS-1:0]   sqx, sqy, sqz;
   logic [SUM_BITS-1:0]         dist_sum;
   logic [CMP_BITS-1:0]         dist_cmp;
   logic                        keep_mid;
   logic                        keep_final;

   logic         out_free;
   logic         emit_now;
   logic         emit_two;
   rsp_word_type first_word;
   rsp_word_type second_word;

   assign dx = DIFF_BITS'(q_head.x) - DIFF_BITS'(held_x_ff);
   assign dy = DIFF_BITS'(q_head.y) - DIFF_BITS'(held_y_ff);
   assign dz = DIFF_BITS'(q_head.z) - DIFF_BITS'(held_z_ff);

   assign sqx = dx * dx;
   assign sqy = dy * dy;
   assign sqz = dz * dz;

   assign dist_sum   = {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
   assign dist_cmp   = CMP_BITS'(dist_sum);
   assign keep_mid   = dist_cmp >= CMP_BITS'(min_space_sq);
   assign keep_final = (dist_cmp > CMP_BITS'(end_eps_sq)) | ~any_emitted_ff;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      emit_now    = 1'b0;
      emit_two    = 1'b0;
      first_word  = '{kept_x: held_x_ff, kept_y: held_y_ff, kept_z: held_z_ff,
                      end_of_output_path: 1'b0, too_short: 1'b0};
      second_word = '{kept_x: q_head.x, kept_y: q_head.y, kept_z: q_head.z,
                      end_of_output_path: 1'b1, too_short: 1'b0};
      case (q_head.kind)
         KIND_FIRST: begin
            emit_now = 1'b0;
         end
         KIND_MIDDLE: begin
            emit_now = keep_mid;
         end
         KIND_SHORT: begin
            emit_now   = 1'b1;
            first_word = '{kept_x: '0, kept_y: '0, kept_z: '0,
                           end_of_output_path: 1'b1, too_short: 1'b1};
         end
         KIND_FINAL: begin
            emit_now = 1'b1;
            emit_two = keep_final;
            first_word.end_of_output_path = ~keep_final;
         end
         default: begin
            emit_now = 1'b0;
         end
      endcase
   end

   // the second word of a final point waits in the pending slot; nothing is popped meanwhile
   assign q_pop = q_stat.avail & ~pend_valid_ff & (out_free | ~emit_now);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff      <= '0;
         held_y_ff      <= '0;
         held_z_ff      <= '0;
         any_emitted_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pend_valid_ff  <= 1'b0;
      end else begin
         if (pend_valid_ff) begin
            if (out_free) begin
               rsp_valid_ff  <= 1'b1;
               rsp_word_ff   <= pend_word_ff;
               pend_valid_ff <= 1'b0;
            end
         end else if (q_pop && emit_now) begin
            rsp_valid_ff  <= 1'b1;
            rsp_word_ff   <= first_word;
            pend_valid_ff <= emit_two;
            pend_word_ff  <= second_word;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end

         if (q_pop) begin
            case (q_head.kind)
               KIND_FIRST: begin
                  held_x_ff      <= q_head.x;
                  held_y_ff      <= q_head.y;
                  held_z_ff      <= q_head.z;
                  any_emitted_ff <= 1'b0;
               end
               KIND_MIDDLE: begin
                  if (keep_mid) begin
                     held_x_ff      <= q_head.x;
                     held_y_ff      <= q_head.y;
                     held_z_ff      <= q_head.z;
                     any_emitted_ff <= 1'b1;
                  end
               end
               KIND_SHORT, KIND_FINAL: begin
                  any_emitted_ff <= 1'b0;
               end
               default: begin
                  any_emitted_ff <= any_emitted_ff;
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: hw/rtl/toolpath_point_decimator.sv
// ----------------------------------------------------------------------------
// toolpath_point_decimator
// Radial distance decimation of a streamed 3D toolpath, marking path ends.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | word
//   --------+----------------------+-------------------------------------------
//   req     | req_valid/req_stall  | point_x/y/z, end_of_input_path
//   rsp     | rsp_valid/rsp_stall  | kept_x/y/z, end_of_output_path, too_short
//   csr     | csr_valid/csr_ready  | csr_index, csr_data (50 bits)
//
// One point is accepted per cycle while req_stall is low. A final point that
// yields two words (held point plus the final point) parks the second word in
// a pending slot, and the queue is not popped until it moves on. The distance
// test (subtract, three squares, sum, compare) is combinational on the held
// point. A kept point passes the front register, a queue slot and the output register.
// Reset is synchronous and active high; the config registers return to their defaults.
// The front and back are split by a four-word queue, so an output stall only
// reaches req_stall once the queue and the front register have filled.
//
module toolpath_point_decimator import tpd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // input points
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_word_type            req_word,
   // reduced path
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_word_type            rsp_word,
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_data
);

   logic [CFG_BITS-1:0] min_space_sq_ff;
   logic [CFG_BITS-1:0] end_eps_sq_ff;

   q_stat_type  q_stat;
   logic        q_push;
   logic        q_pop;
   q_entry_type q_push_entry;
   q_entry_type q_head;

   // writes are always taken; an unknown index is dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_space_sq_ff <= MIN_SPACE_SQ_RESET;
         end_eps_sq_ff   <= END_EPS_SQ_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_SPACE_SQ: begin
               min_space_sq_ff <= csr_data;
            end
            CSR_END_EPS_SQ: begin
               end_eps_sq_ff <= csr_data;
            end
            default: begin
               min_space_sq_ff <= min_space_sq_ff;
            end
         endcase
      end
   end

   // front: registers the point and tags first / middle / final / too short
   tpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_entry   (q_push_entry)
   );

   tpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .stat       (q_stat)
   );

   // back: distance test, held point, output register and second-word slot
   tpd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .min_space_sq (min_space_sq_ff),
      .end_eps_sq   (end_eps_sq_ff),
      .q_stat       (q_stat),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word)
   );

endmodule

// File: tb/sv/tb_toolpath_point_decimator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_toolpath_point_decimator
// Self-checking bench for the radial distance toolpath decimator.
// Streams paths of 3D points, predicts the reduced path with a local model
// of the keep/drop rules and compares every output word in order. Covers
// short paths, end-of-path epsilon rules, register extremes, random idle on
// both channels, and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_toolpath_point_decimator;
   import tpd_pkg::*;

   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 4;
   // give the pipe slack before a register write
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 64;
   localparam int QUIET_LIMIT   = 2000;
   localparam int PRINT_LIMIT   = 40;
   localparam int FULL_SPAN     = 0;

   localparam coord_type C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic [CFG_BITS-1:0] CFG_MAX = {CFG_BITS{1'b1}};
   // an index with no register behind it; writes must be dropped
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = CSR_IDX_BITS'(7);

   // ---------------------------------------------------------------------------
   // DUT connections; every input starts at a known value
   // ---------------------------------------------------------------------------
   logic                    clock;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_word_type            req_word  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_word_type            rsp_word;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]     csr_data  = '0;

   toolpath_point_decimator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Decimator model state, updated on every accepted input word
   // ---------------------------------------------------------------------------
   logic [CFG_BITS-1:0] min_spacing_sq = MIN_SPACE_SQ_RESET;
   logic [CFG_BITS-1:0] end_spacing_sq = END_EPS_SQ_RESET;
   coord_type           held_x = '0, held_y = '0, held_z = '0;
   int                  path_pos  = 0;    // 0 = path start, 1 = one point, 2 = more
   bit                  held_sent = 1'b0; // some kept point of this path went out

   rsp_word_type kept_expect[$];          // reduced-path words still to come

   int  mismatches  = 0;
   int  points_sent = 0;
   bit  idle_on     = 1'b1;               // random idle on both channels
   int  hold_asks   = 0;                  // bumped by a test to request a hold-off
   int  hold_seen   = 0;
   int  hold_left   = 0;
   int  quiet_cycles = 0;

   function automatic rsp_word_type kept_word(input coord_type x, y, z,
                                              input bit end_mark, input bit shrt);
      rsp_word_type r;
      r.kept_x             = x;
      r.kept_y             = y;
      r.kept_z             = z;
      r.end_of_output_path = end_mark;
      r.too_short          = shrt;
      return r;
   endfunction

   // append one word at the tail of the expected stream
   function automatic void expect_word(input rsp_word_type w);
      kept_expect.insert(kept_expect.size(), w);
   endfunction

   // exact squared distance from the held point; max is ~3 * 2^48, fits easily
   function automatic logic [63:0] spacing_sq(input req_word_type w);
      longint dx, dy, dz;
      dx = w.point_x - held_x;
      dy = w.point_y - held_y;
      dz = w.point_z - held_z;
      return 64'(dx * dx + dy * dy + dz * dz);
   endfunction

   function automatic void decimate_point(input req_word_type w);
      logic [63:0] d;
      d = spacing_sq(w);
      if (path_pos == 0) begin
         if (w.end_of_input_path) begin
            expect_word(kept_word('0, '0, '0, 1'b1, 1'b1));
         end else begin
            held_x    = w.point_x;
            held_y    = w.point_y;
            held_z    = w.point_z;
            held_sent = 1'b0;
            path_pos  = 1;
         end
      end else if (!w.end_of_input_path) begin
         // middle point: emit the held one and take its place when far enough
         if (d >= 64'(min_spacing_sq)) begin
            expect_word(kept_word(held_x, held_y, held_z, 1'b0, 1'b0));
            held_x    = w.point_x;
            held_y    = w.point_y;
            held_z    = w.point_z;
            held_sent = 1'b1;
         end
         path_pos = 2;
      end else begin
         if (path_pos == 1) begin
            expect_word(kept_word('0, '0, '0, 1'b1, 1'b1));
         end else if (d > 64'(end_spacing_sq) || !held_sent) begin
            expect_word(kept_word(held_x, held_y, held_z, 1'b0, 1'b0));
            expect_word(kept_word(w.point_x, w.point_y, w.point_z, 1'b1, 1'b0));
         end else begin
            expect_word(kept_word(held_x, held_y, held_z, 1'b1, 1'b0));
         end
         path_pos  = 0;
         held_sent = 1'b0;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Mismatch reporting; print is capped, count is not
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("[%0t] MISMATCH %s: got %0h, want %0h", $realtime, what, got, want);
   endtask

   // ---------------------------------------------------------------------------
   // Result checker: each accepted word against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (kept_expect.size() == 0) begin
            report_mismatch("word with none expected", 64'(rsp_word), 64'd0);
         end else begin
            want = kept_expect.pop_front();
            if (rsp_word.kept_x !== want.kept_x)
               report_mismatch("kept_x", 64'(rsp_word.kept_x), 64'(want.kept_x));
            if (rsp_word.kept_y !== want.kept_y)
               report_mismatch("kept_y", 64'(rsp_word.kept_y), 64'(want.kept_y));
            if (rsp_word.kept_z !== want.kept_z)
               report_mismatch("kept_z", 64'(rsp_word.kept_z), 64'(want.kept_z));
            if (rsp_word.end_of_output_path !== want.end_of_output_path)
               report_mismatch("end_of_output_path", 64'(rsp_word.end_of_output_path),
                               64'(want.end_of_output_path));
            if (rsp_word.too_short !== want.too_short)
               report_mismatch("too_short", 64'(rsp_word.too_short),
                               64'(want.too_short));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver stall: random idle, or a counted hold-off on request
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 24);
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: too long with no word moving on any channel
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic req_word_type pt(input int x, y, z, input bit last_pt);
      req_word_type w;
      w.point_x           = COORD_BITS'(x);
      w.point_y           = COORD_BITS'(y);
      w.point_z           = COORD_BITS'(z);
      w.end_of_input_path = last_pt;
      return w;
   endfunction

   function automatic coord_type nudge(input coord_type c, input int span);
      if (span == FULL_SPAN)
         return coord_type'($urandom);
      return COORD_BITS'(c + int'($urandom_range(2 * span)) - span);
   endfunction

   // one word on req; valid stays up across back-to-back words
   task automatic send_point(input req_word_type w);
      if (idle_on && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      decimate_point(w);
      points_sent++;
   endtask

   // sender pause: drop valid, wait out every expected word, then the pipe
   task automatic settle_block();
      req_valid <= 1'b0;
      while (kept_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // valid drops after each write
   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MIN_SPACE_SQ)
         min_spacing_sq = val;
      else if (idx == CSR_END_EPS_SQ)
         end_spacing_sq = val;
      @(posedge clock);
   endtask

   task automatic set_spacing(input logic [CFG_BITS-1:0] min_sq,
                              input logic [CFG_BITS-1:0] eps_sq);
      settle_block();
      write_csr(CSR_MIN_SPACE_SQ, min_sq);
      write_csr(CSR_END_EPS_SQ, eps_sq);
   endtask

   // a random walk path; final point optionally parked right next to the
   // held point to exercise the end epsilon test
   task automatic send_path(input int len, input int span, input bit end_near);
      req_word_type w;
      int i;
      w.point_x = coord_type'($urandom);
      w.point_y = coord_type'($urandom);
      w.point_z = coord_type'($urandom);
      for (i = 0; i < len; i++) begin
         w.end_of_input_path = (i == len - 1);
         if (i > 0) begin
            if (w.end_of_input_path && end_near && path_pos == 2) begin
               w.point_x = nudge(held_x, 2);
               w.point_y = nudge(held_y, 2);
               w.point_z = nudge(held_z, 2);
            end else begin
               w.point_x = nudge(w.point_x, span);
               w.point_y = nudge(w.point_y, span);
               w.point_z = nudge(w.point_z, span);
            end
         end
         send_point(w);
      end
   endtask

   task automatic random_paths(input int n_points);
      int target, len, span, r;
      target = points_sent + n_points;
      while (points_sent < target) begin
         r = $urandom_range(99);
         if (r < 6)
            len = 1;
         else if (r < 12)
            len = 2;
         else
            len = $urandom_range(3, 16);
         case ($urandom_range(5))
            0:       span = 4;
            1:       span = 64;
            2:       span = 256;
            3:       span = 512;
            4:       span = 4096;
            default: span = FULL_SPAN;
         endcase
         send_path(len, span, $urandom_range(99) < 30);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   task automatic test_directed_cases();
      // lone final point -> too-short marker
      send_point(pt(C_MAX, C_MAX, C_MAX, 1'b1));
      // two points -> too-short marker
      send_point(pt(C_MIN, C_MIN, C_MIN, 1'b0));
      send_point(pt(C_MAX, C_MAX, C_MAX, 1'b1));
      // widest jump keeps the middle; final equal to held folds into one word
      send_point(pt(C_MAX, C_MAX, C_MAX, 1'b0));
      send_point(pt(C_MIN, C_MIN, C_MIN, 1'b0));
      send_point(pt(C_MIN, C_MIN, C_MIN, 1'b1));
      // nothing emitted yet: final point is appended even inside epsilon
      send_point(pt(0, 0, 0, 1'b0));
      send_point(pt(1, 1, 1, 1'b0));
      send_point(pt(2, 2, 2, 1'b1));
      // final exactly at epsilon: dropped
      send_point(pt(0, 0, 0, 1'b0));
      send_point(pt(1000, 0, 0, 1'b0));
      send_point(pt(1004, 0, 0, 1'b1));
      // one unit past epsilon, negative coordinates: appended
      send_point(pt(-7, -9, -11, 1'b0));
      send_point(pt(-1007, -9, -11, 1'b0));
      send_point(pt(-1011, -9, -10, 1'b1));
      // middle spacing exactly at the minimum is kept, one short of it is not
      set_spacing(CFG_BITS'(40000), END_EPS_SQ_RESET);
      send_point(pt(0, 0, 0, 1'b0));
      send_point(pt(199, 0, 0, 1'b0));
      send_point(pt(0, 200, 0, 1'b0));
      send_point(pt(0, 200, -3000, 1'b1));
   endtask

   task automatic test_register_extremes();
      set_spacing('0, '0);             // every middle kept, any move appends
      random_paths(60);
      set_spacing(CFG_MAX, CFG_MAX);   // no middle kept, final only if alone
      random_paths(60);
      set_spacing('0, CFG_MAX);
      random_paths(60);
      set_spacing(CFG_MAX, '0);
      random_paths(60);
      // writes to an unmapped index must leave both registers alone
      set_spacing(MIN_SPACE_SQ_RESET, END_EPS_SQ_RESET);
      write_csr(CSR_UNUSED, CFG_MAX);
      write_csr(CSR_UNUSED, '0);
      random_paths(60);
   endtask

   task automatic test_output_holdoff();
      settle_block();
      // receiver holds off while the sender keeps offering, so the queue
      // and front fill and req_stall must rise
      idle_on   <= 1'b0;
      hold_asks <= hold_asks + 1;
      random_paths(40);
      settle_block();
      idle_on <= 1'b1;
   endtask

   task automatic test_random_paths();
      int phase;
      for (phase = 0; phase < 7; phase++) begin
         if (phase == 6)
            set_spacing(MIN_SPACE_SQ_RESET, END_EPS_SQ_RESET);
         else
            set_spacing(CFG_BITS'($urandom_range(2000000)),
                        CFG_BITS'($urandom_range(5000)));
         // one phase runs with no idle on either side
         idle_on <= (phase != 3);
         random_paths(120);
      end
      // a pair of fully random 50-bit settings to toggle every register bit
      set_spacing(CFG_BITS'({$urandom, $urandom}), CFG_BITS'({$urandom, $urandom}));
      random_paths(40);
      set_spacing(~min_spacing_sq, ~end_spacing_sq);
      random_paths(40);
      idle_on <= 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_register_extremes();
      test_output_holdoff();
      test_random_paths();

      settle_block();
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_front.sv
hw/rtl/tpd_queue.sv
hw/rtl/tpd_back.sv
hw/rtl/toolpath_point_decimator.sv
tb/sv/tb_toolpath_point_decimator.sv
